// File: hw/rtl/bal_pkg.sv
// Buddy allocator package: sizes, node word layout, request and result types,
// the status codes and the controller states. Used by bal_engine and the top level.
// No dependencies.
`default_nettype none

package bal_pkg;

  // Tree geometry
  localparam int LEAF_LOG      = 16;
  localparam int MIN_BLOCK_LOG = 4;
  localparam int NW            = LEAF_LOG + 1;          // node index width
  localparam int LW            = LEAF_LOG + 1;          // one mask bit per tree level
  localparam int LVW           = $clog2(LEAF_LOG + 1);  // level number width
  localparam int LEAF_W        = LEAF_LOG + 1;          // leaf counts, up to 2^LEAF_LOG

  // Field widths
  localparam int POOL_W = 21;
  localparam int REQ_W  = 21;
  localparam int ADDR_W = 20;
  localparam int PEND_W = 17;
  localparam int OFF_W  = ADDR_W - MIN_BLOCK_LOG;
  localparam int BL_W   = $clog2(REQ_W + 1);

  // Stream widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic [POOL_W-1:0] POOL_RESET = 21'h100000;
  localparam logic [PEND_W-1:0] PEND_MAX   = '1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_B_INIT, S_B_PATH, S_B_RIGHT,
    S_IDLE,
    S_A_ROOT, S_A_PICK, S_A_DESC, S_SPLIT,
    S_UP_RD, S_UP_WR,
    S_F_CHK, S_F_WALK, S_M_RD, S_M_CHK, S_M_PAR,
    S_DONE
  } state_e;

  // One tree node: split mark and the set of levels holding a free block below
  typedef struct packed {
    logic          split;
    logic [LW-1:0] mask;
  } node_word_t;

  typedef struct packed {
    logic [LEAF_W-1:0] leaf_n;
    logic [LVW-1:0]    depth;
    logic [LEAF_W-1:0] prefix;
    logic [LW-1:0]     rfree;   // levels of the free right children on the prefix path
  } layout_t;

  typedef struct packed {
    logic              is_free;
    logic [REQ_W-1:0]  bytes;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [PEND_W-1:0] pending;
  } res_t;

  // Number of bits needed to hold v
  function automatic logic [BL_W-1:0] bit_len(input logic [REQ_W-1:0] v);
    logic [BL_W-1:0] r;
    r = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (v[i]) r = BL_W'(i + 1);
    end
    return r;
  endfunction

  // Levels 0..l set
  function automatic logic [LW-1:0] lvl_low(input logic [LVW-1:0] l);
    logic [LW:0] t;
    t = (LW + 1)'(2) << l;
    return LW'(t - 1'b1);
  endfunction

  function automatic logic [LW-1:0] lvl_one(input logic [LVW-1:0] l);
    return LW'(1) << l;
  endfunction

  // Bits below position n
  function automatic logic [LEAF_W-1:0] leaf_low(input logic [LVW-1:0] n);
    logic [LEAF_W:0] t;
    t = (LEAF_W + 1)'(1) << n;
    return LEAF_W'(t - 1'b1);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bal_engine.sv
// Buddy allocator engine: node memory plus the sequencer that clears, builds,
// allocates, frees and merges. Depends on bal_pkg.
`default_nettype none

module bal_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  bal_pkg::layout_t layout_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  bal_pkg::req_t   req_i,
  input  logic            out_free_i,
  output logic            res_valid_o,
  output bal_pkg::res_t   res_o
);
  import bal_pkg::*;

  state_e state_q, state_d;

  logic [NW-1:0]     node_q, node_d, x_q, x_d, clr_q, clr_d;
  logic [LVW-1:0]    lvl_q, lvl_d, tgt_q, tgt_d, d_q, d_d, k_q, k_d;
  logic [LW-1:0]     acc_q, acc_d;
  logic              phase_q, phase_d;
  logic [LEAF_W-1:0] leaf_q, leaf_d;
  req_t              req_q, req_d;
  res_t              res_q, res_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [ADDR_W-1:0] gaddr_q, gaddr_d;

  // Node memory, one word per tree node, read data registered
  node_word_t ram [2**NW];
  node_word_t rd_q, wdata;
  logic       we, re;
  logic [NW-1:0] waddr, raddr;

  always_ff @(posedge clk_i) begin
    if (we) ram[waddr] <= wdata;
    if (re) rd_q <= ram[raddr];
  end

  // Shared decode
  logic [NW-1:0]     node_l, node_r, parent, sib, child_desc;
  logic [REQ_W-1:0]  bytes_m1;
  logic [BL_W-1:0]   bl;
  logic              small_req, too_big, sel_none, desc_left;
  logic [LVW-1:0]    k_c, d_c, e_c, lvl_nx, sh;
  logic [LW-1:0]     sel;
  logic              can_go, wbit, aligned, here_free;
  logic              misal, beyond, bbit, blast;
  logic [OFF_W-1:0]  off;
  logic [LEAF_W-1:0] leaf_c, start;
  logic              fin;
  status_e           fin_st;

  assign node_l     = {node_q[NW-2:0], 1'b0};
  assign node_r     = {node_q[NW-2:0], 1'b1};
  assign parent     = {1'b0, node_q[NW-1:1]};
  assign sib        = node_q ^ NW'(1);
  assign lvl_nx     = lvl_q + LVW'(1);

  // Size class of an allocate word
  assign bytes_m1   = req_q.bytes - REQ_W'(1);
  assign bl         = bit_len(bytes_m1);
  assign small_req  = req_q.bytes <= REQ_W'(1 << MIN_BLOCK_LOG);
  assign k_c        = small_req ? '0 : LVW'(bl - BL_W'(MIN_BLOCK_LOG));
  assign too_big    = k_c > layout_i.depth;
  assign d_c        = layout_i.depth - k_c;

  // Deepest level up to d with a free block, then leftmost descent
  assign sel        = rd_q.mask & lvl_low(d_q);
  assign sel_none   = (sel == '0);
  assign e_c        = LVW'(bit_len(REQ_W'(sel)) - BL_W'(1));
  assign desc_left  = rd_q.mask[tgt_q];
  assign child_desc = {node_q[NW-2:0], ~desc_left};

  // Walk towards a leaf
  assign sh         = layout_i.depth - lvl_q - LVW'(1);
  assign can_go     = (lvl_q < layout_i.depth) && rd_q.split;
  assign wbit       = leaf_q[sh];
  assign aligned    = (leaf_q & leaf_low(layout_i.depth - lvl_q)) == '0;
  assign here_free  = rd_q.mask[lvl_q];

  // Free word checks
  assign misal      = req_q.addr[MIN_BLOCK_LOG-1:0] != '0;
  assign off        = req_q.addr[ADDR_W-1:MIN_BLOCK_LOG];
  assign beyond     = LEAF_W'(off) >= layout_i.leaf_n;
  assign leaf_c     = layout_i.prefix + LEAF_W'(off);

  // Prefix boundary path
  assign bbit       = layout_i.prefix[sh];
  assign blast      = (layout_i.prefix & leaf_low(layout_i.depth - lvl_q)) ==
                      (LEAF_W'(1) << sh);

  // Start leaf of the granted block
  assign start      = LEAF_W'((node_q & NW'(leaf_low(d_q))) << k_q);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE) && out_free_i;
  assign res_o       = res_q;

  // Memory controls and completion
  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    waddr  = node_q;
    raddr  = node_q;
    wdata  = '0;
    fin    = 1'b0;
    fin_st = ST_OK;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      S_B_INIT: begin
        if (layout_i.prefix == '0) begin
          we         = 1'b1;
          waddr      = NW'(1);
          wdata.mask = lvl_one('0);
        end
      end
      S_B_PATH: begin
        we          = 1'b1;
        wdata.split = 1'b1;
        wdata.mask  = layout_i.rfree & ~lvl_low(lvl_q);
      end
      S_B_RIGHT: begin
        we         = !bbit || blast;
        waddr      = node_r;
        wdata.mask = lvl_one(lvl_nx);
      end
      S_A_ROOT: begin
        if (too_big) begin
          fin    = 1'b1;
          fin_st = ST_NO_SPACE;
        end else begin
          re    = 1'b1;
          raddr = NW'(1);
        end
      end
      S_A_PICK: begin
        if (sel_none) begin
          fin    = 1'b1;
          fin_st = ST_NO_SPACE;
        end else if (e_c != '0) begin
          re    = 1'b1;
          raddr = NW'(2);
        end
      end
      S_A_DESC: begin
        if (lvl_nx != tgt_q) begin
          re    = 1'b1;
          raddr = {child_desc[NW-2:0], 1'b0};
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        if (lvl_q == d_q) begin
          wdata = '0;
        end else if (!phase_q) begin
          wdata.split = 1'b1;
          wdata.mask  = lvl_low(d_q) & ~lvl_low(lvl_q);
        end else begin
          waddr      = node_r;
          wdata.mask = lvl_one(lvl_nx);
        end
      end
      S_UP_RD: begin
        if (node_q == NW'(1)) begin
          fin = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = sib;
        end
      end
      S_UP_WR: begin
        we          = 1'b1;
        waddr       = parent;
        wdata.split = 1'b1;
        wdata.mask  = acc_q | rd_q.mask;
        if (parent == NW'(1)) begin
          fin = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = parent ^ NW'(1);
        end
      end
      S_F_CHK: begin
        if (misal || beyond) begin
          fin    = 1'b1;
          fin_st = ST_BAD_ADDR;
        end else begin
          re    = 1'b1;
          raddr = NW'(1);
        end
      end
      S_F_WALK: begin
        if (can_go) begin
          re    = 1'b1;
          raddr = {node_q[NW-2:0], wbit};
        end else if (!aligned) begin
          fin    = 1'b1;
          fin_st = ST_BAD_ADDR;
        end else if (here_free) begin
          fin    = 1'b1;
          fin_st = ST_NOT_ALLOC;
        end
      end
      S_M_RD: begin
        if (node_q == NW'(1)) begin
          we         = 1'b1;
          wdata.mask = lvl_one('0);
          fin        = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = sib;
        end
      end
      S_M_CHK: begin
        we = 1'b1;
        if (here_free) begin
          waddr = sib;
        end else begin
          wdata.mask = lvl_one(lvl_q);
        end
      end
      S_M_PAR: begin
        we    = 1'b1;
        waddr = parent;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_q == '1) state_d = S_B_INIT;
      S_B_INIT: begin
        if (layout_i.prefix == '0 || layout_i.leaf_n == '0) state_d = S_IDLE;
        else state_d = S_B_PATH;
      end
      S_B_PATH:  state_d = S_B_RIGHT;
      S_B_RIGHT: state_d = blast ? S_IDLE : S_B_PATH;
      S_IDLE: begin
        if (req_valid_i) state_d = req_i.is_free ? S_F_CHK : S_A_ROOT;
      end
      S_A_ROOT:  state_d = S_A_PICK;
      S_A_PICK:  if (!sel_none) state_d = (e_c == '0) ? S_SPLIT : S_A_DESC;
      S_A_DESC:  if (lvl_nx == tgt_q) state_d = S_SPLIT;
      S_SPLIT:   if (lvl_q == d_q) state_d = S_UP_RD;
      S_UP_RD:   state_d = S_UP_WR;
      S_UP_WR:   ;
      S_F_CHK:   state_d = S_F_WALK;
      S_F_WALK:  if (!can_go) state_d = S_M_RD;
      S_M_RD:    state_d = S_M_CHK;
      S_M_CHK:   state_d = here_free ? S_M_PAR : S_UP_WR;
      S_M_PAR:   state_d = S_M_RD;
      S_DONE:    if (out_free_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
    if (fin) state_d = S_DONE;
    if (restart_i) state_d = S_CLEAR;
  end

  // Datapath registers
  always_comb begin
    node_d  = node_q;
    x_d     = x_q;
    clr_d   = clr_q;
    lvl_d   = lvl_q;
    tgt_d   = tgt_q;
    d_d     = d_q;
    k_d     = k_q;
    acc_d   = acc_q;
    phase_d = phase_q;
    leaf_d  = leaf_q;
    req_d   = req_q;
    res_d   = res_q;
    pend_d  = pend_q;
    gaddr_d = gaddr_q;
    case (state_q)
      S_CLEAR:  clr_d = clr_q + NW'(1);
      S_B_INIT: begin
        node_d = NW'(1);
        lvl_d  = '0;
      end
      S_B_RIGHT: begin
        node_d = {node_q[NW-2:0], bbit};
        lvl_d  = lvl_nx;
      end
      S_IDLE:   if (req_valid_i) req_d = req_i;
      S_A_ROOT: begin
        k_d = k_c;
        d_d = d_c;
      end
      S_A_PICK: begin
        tgt_d   = e_c;
        node_d  = NW'(1);
        x_d     = NW'(1);
        lvl_d   = '0;
        phase_d = 1'b0;
      end
      S_A_DESC: begin
        node_d = child_desc;
        x_d    = child_desc;
        lvl_d  = lvl_nx;
      end
      S_SPLIT: begin
        if (lvl_q == d_q) begin
          gaddr_d = ADDR_W'({OFF_W'(start - layout_i.prefix), {MIN_BLOCK_LOG{1'b0}}});
          node_d  = x_q;
          lvl_d   = tgt_q;
          acc_d   = lvl_low(d_q) & ~lvl_low(tgt_q);
        end else if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          node_d  = node_l;
          lvl_d   = lvl_nx;
        end
      end
      S_UP_WR: begin
        acc_d  = acc_q | rd_q.mask;
        node_d = parent;
        lvl_d  = lvl_q - LVW'(1);
      end
      S_F_CHK: begin
        leaf_d = leaf_c;
        node_d = NW'(1);
        lvl_d  = '0;
      end
      S_F_WALK: begin
        if (can_go) begin
          node_d = {node_q[NW-2:0], wbit};
          lvl_d  = lvl_nx;
        end
      end
      S_M_CHK:  if (!here_free) acc_d = lvl_one(lvl_q);
      S_M_PAR: begin
        node_d = parent;
        lvl_d  = lvl_q - LVW'(1);
      end
      default: ;
    endcase
    // Result word on completion
    if (fin) begin
      if (fin_st == ST_OK) begin
        if (req_q.is_free) begin
          if (pend_q != '0) pend_d = pend_q - PEND_W'(1);
        end else if (pend_q != PEND_MAX) begin
          pend_d = pend_q + PEND_W'(1);
        end
      end
      res_d.status  = fin_st;
      res_d.addr    = (fin_st == ST_OK && !req_q.is_free) ? gaddr_q : '0;
      res_d.pending = pend_d;
    end
    if (restart_i) begin
      clr_d  = '0;
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    x_q     <= x_d;
    lvl_q   <= lvl_d;
    tgt_q   <= tgt_d;
    d_q     <= d_d;
    k_q     <= k_d;
    acc_q   <= acc_d;
    phase_q <= phase_d;
    leaf_q  <= leaf_d;
    req_q   <= req_d;
    res_q   <= res_d;
    gaddr_q <= gaddr_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/buddy_allocator_top.sv
// Buddy allocator top level: stream ports, pool length register, layout
// derivation and result register. Depends on bal_pkg and bal_engine.
//
// Usage: one request word in on s_axis (tuser = 0 allocate, 1 free), one
// result word out on m_axis for each request, in order. A request is taken
// only while the engine is idle; its result waits in an output register, so
// the next request is taken while an earlier result is still held.
// The tree depth is at most 16. An allocate reads the root, descends leftmost
// one level a cycle, splits with two node writes a level and refreshes back
// to the root one level a cycle; a free walks down one level a cycle, merges
// through the read, check and parent states a level and refreshes up one
// level a cycle. The one node memory does one read and one write a cycle.
// Failures finish early. Reset or a write of cfg_wdata_i clears the node
// memory one entry a cycle, then lays out the pool; s_axis_tready stays low
// for that time. A stalled m_axis holds its result word and the engine
// waits with the next result.
`default_nettype none

module buddy_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bal_pkg::POOL_W-1:0]        cfg_wdata_i,   // pool_bytes
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [20:0] request_bytes, [40:21] block_address, rest zero
  input  logic [bal_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] req_type
  input  logic [bal_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [19:0] granted_address, [36:20] blocks_pending, rest zero
  output logic [bal_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [bal_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
  import bal_pkg::*;

  logic [POOL_W-1:0] pool_q;
  logic [LEAF_W-1:0] leaf_n_q, prefix_c;
  logic [LVW-1:0]    depth_q;
  logic [LEAF_W-1:0] ln_c;
  logic [LVW-1:0]    depth_c;
  logic [LW-1:0]     rfree_c;
  logic [LVW-1:0]    q;
  layout_t           layout_q;
  req_t              req;
  res_t              res, out_q;
  logic              res_valid, out_valid_q, out_free;

  // Pool length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= POOL_RESET;
    end else if (cfg_we_i) begin
      pool_q <= cfg_wdata_i;
    end
  end

  // Leaf count, saturated, and tree depth
  always_comb begin
    ln_c = LEAF_W'(pool_q >> MIN_BLOCK_LOG);
    if ((pool_q >> MIN_BLOCK_LOG) > POOL_W'(1 << LEAF_LOG)) ln_c = LEAF_W'(1 << LEAF_LOG);
    if (ln_c <= LEAF_W'(1)) depth_c = '0;
    else depth_c = LVW'(bit_len(REQ_W'(ln_c - LEAF_W'(1))));
  end

  // Prefix length and the free right children along its boundary path
  always_comb begin
    prefix_c = (LEAF_W'(1) << depth_q) - leaf_n_q;
    rfree_c  = '0;
    q        = '0;
    for (int lv = 1; lv < LW; lv++) begin
      q = depth_q - LVW'(lv);
      rfree_c[lv] = (LVW'(lv) <= depth_q) &&
                    ((prefix_c & leaf_low(q + LVW'(1))) != '0) &&
                    (!prefix_c[q] || ((prefix_c & leaf_low(q)) == '0));
    end
  end

  always_ff @(posedge clk_i) begin
    leaf_n_q        <= ln_c;
    depth_q         <= depth_c;
    layout_q.leaf_n <= leaf_n_q;
    layout_q.depth  <= depth_q;
    layout_q.prefix <= prefix_c;
    layout_q.rfree  <= rfree_c;
  end

  // Request word unpack
  assign req.is_free = s_axis_tuser[0];
  assign req.bytes   = s_axis_tdata[REQ_W-1:0];
  assign req.addr    = s_axis_tdata[REQ_W+ADDR_W-1:REQ_W];

  bal_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .layout_i    (layout_q),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{(OUT_DATA_W - ADDR_W - PEND_W){1'b0}}, out_q.pending, out_q.addr};

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for buddy_allocator_top: a stream driver and monitor,
// an in-bench allocator predictor and a queue of expected result words.
// Depends on bal_pkg and buddy_allocator_top.
`timescale 1ns / 1ps

module testbench;
  import bal_pkg::*;

  localparam int NODES      = 1 << (LEAF_LOG + 1);
  localparam int LEAVES     = 1 << LEAF_LOG;
  localparam int IDLE_LIMIT = 500000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [POOL_W-1:0]     cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  buddy_allocator_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Allocator state as the testbench sees it
  bit          split_mark [NODES];
  bit          leaf_taken [LEAVES];
  logic [31:0] free_word  [NODES/32];
  int unsigned pool_leaves, tree_lvls, prefix_n, live_blocks;

  req_t        req_q [$];     // words waiting to be offered
  res_t        result_q [$];  // expected result words, oldest first
  int unsigned granted_q [$]; // addresses believed allocated
  int          errors = 0;
  int          results_seen = 0;
  int          reqs_sent = 0;

  function automatic bit free_get(int unsigned i);
    return free_word[i >> 5][i & 31];
  endfunction

  function automatic void free_put(int unsigned i, bit v);
    free_word[i >> 5][i & 31] = v;
  endfunction

  // lowest free node in [lo, hi), zero when none
  function automatic int unsigned first_free(int unsigned lo, int unsigned hi);
    int unsigned i;
    logic [31:0] w;
    i = lo;
    while (i < hi) begin
      w = free_word[i >> 5] >> (i & 31);
      if (w == 0) i = (i | 31) + 1;
      else if (w[0]) return i;
      else i++;
    end
    return 0;
  endfunction

  // Rebuild the tree for a new pool length
  function automatic void lay_out_pool(logic [POOL_W-1:0] pool);
    int unsigned node, lo, span, half, mid;
    foreach (split_mark[i]) split_mark[i] = 1'b0;
    foreach (leaf_taken[i]) leaf_taken[i] = 1'b0;
    foreach (free_word[i]) free_word[i] = '0;
    live_blocks = 0;
    granted_q.delete();
    pool_leaves = pool >> MIN_BLOCK_LOG;
    if (pool_leaves > LEAVES) pool_leaves = LEAVES;
    tree_lvls = 0;
    while (tree_lvls < LEAF_LOG && (1 << tree_lvls) < pool_leaves) tree_lvls++;
    prefix_n = (1 << tree_lvls) - pool_leaves;
    for (int i = 0; i < prefix_n; i++) leaf_taken[i] = 1'b1;
    if (prefix_n == 0) begin
      free_put(1, 1'b1);
      return;
    end
    if (prefix_n >= (1 << tree_lvls)) return;
    node = 1; lo = 0; span = 1 << tree_lvls;
    forever begin
      half = span >> 1;
      mid  = lo + half;
      split_mark[node] = 1'b1;
      if (prefix_n < mid) begin
        free_put(2*node + 1, 1'b1);
        node = 2*node; span = half;
      end else if (prefix_n == mid) begin
        free_put(2*node + 1, 1'b1);
        break;
      end else begin
        node = 2*node + 1; lo = mid; span = half;
      end
    end
  endfunction

  function automatic status_e grant_block(logic [REQ_W-1:0] bytes, output int unsigned addr);
    int unsigned k, d, e, node, start;
    k = 0; node = 0; addr = 0;
    while (k <= tree_lvls && (longint'(1) << (k + MIN_BLOCK_LOG)) < bytes) k++;
    if (k > tree_lvls) return ST_NO_SPACE;
    d = tree_lvls - k;
    e = d;
    forever begin
      node = first_free(1 << e, 2 << e);
      if (node != 0 || e == 0) break;
      e--;
    end
    if (node == 0) return ST_NO_SPACE;
    free_put(node, 1'b0);
    // split down, keeping the left half
    while (e < d) begin
      split_mark[node] = 1'b1;
      node = 2*node;
      free_put(node + 1, 1'b1);
      e++;
    end
    start = (node - (1 << d)) << k;
    for (int i = 0; i < (1 << k); i++) leaf_taken[start + i] = 1'b1;
    if (live_blocks < 32'h1FFFF) live_blocks++;
    addr = (start - prefix_n) << MIN_BLOCK_LOG;
    return ST_OK;
  endfunction

  function automatic status_e release_block(logic [ADDR_W-1:0] a);
    int unsigned leaf, node, e, start;
    node = 1; e = 0;
    if (a[MIN_BLOCK_LOG-1:0] != 0) return ST_BAD_ADDR;
    if ((a >> MIN_BLOCK_LOG) >= pool_leaves) return ST_BAD_ADDR;
    leaf = prefix_n + (a >> MIN_BLOCK_LOG);
    while (e < tree_lvls && split_mark[node]) begin
      node = 2*node + ((leaf >> (tree_lvls - e - 1)) & 1);
      e++;
    end
    start = (node - (1 << e)) << (tree_lvls - e);
    if (start != leaf) return ST_BAD_ADDR;
    if (free_get(node) || !leaf_taken[leaf]) return ST_NOT_ALLOC;
    for (int i = 0; i < (1 << (tree_lvls - e)); i++) leaf_taken[start + i] = 1'b0;
    // merge free buddies upward
    while (node > 1 && free_get(node ^ 1)) begin
      free_put(node ^ 1, 1'b0);
      node >>= 1;
      split_mark[node] = 1'b0;
    end
    free_put(node, 1'b1);
    if (live_blocks > 0) live_blocks--;
    return ST_OK;
  endfunction

  // Work out the result of one accepted word
  function automatic void predict_result(req_t r);
    res_t        x;
    int unsigned a;
    int          idx [$];
    a = 0;
    if (!r.is_free) begin
      x.status = grant_block(r.bytes, a);
      if (x.status == ST_OK) granted_q.push_back(a);
    end else begin
      x.status = release_block(r.addr);
      if (x.status == ST_OK) begin
        idx = granted_q.find_first_index(g) with (g == r.addr);
        if (idx.size() > 0) granted_q.delete(idx[0]);
      end
    end
    if (x.status != ST_OK) a = 0;
    x.addr    = ADDR_W'(a);
    x.pending = PEND_W'(live_blocks);
    result_q.push_back(x);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued words, random gaps between them
  int unsigned in_gap = 0;
  req_t        cur_req;
  always @(posedge clk_i) begin
    logic nv;
    logic holding;
    holding = s_axis_tvalid && !s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      predict_result(cur_req);
      reqs_sent++;
    end
    nv = holding;
    if (!holding) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (req_q.size() > 0) begin
        cur_req = req_q.pop_front();
        nv = 1'b1;
        in_gap = ((reqs_sent / 150) % 4 == 3) ? 0 : gap_len();
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= {7'b0, cur_req.addr, cur_req.bytes};
    s_axis_tuser  <= cur_req.is_free;
  end

  // Monitor: checks each result word against the oldest expectation
  int unsigned out_hold = 0;
  int unsigned long_hold = 0;
  always @(posedge clk_i) begin
    res_t exp_r;
    logic nr;
    if (m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word status=%0d addr=%h pending=%0d", $time,
                 m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[36:20]);
        errors++;
      end else begin
        exp_r = result_q.pop_front();
        if (m_axis_tuser != exp_r.status || m_axis_tdata[19:0] != exp_r.addr ||
            m_axis_tdata[36:20] != exp_r.pending || m_axis_tdata[39:37] != 0) begin
          $display("%0t: mismatch expected status=%0d addr=%h pending=%0d, got status=%0d addr=%h pending=%0d",
                   $time, exp_r.status, exp_r.addr, exp_r.pending,
                   m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[36:20]);
          errors++;
        end
      end
      results_seen++;
      if (results_seen == 150) long_hold = 600;
    end
    nr = 1'b0;
    if (long_hold > 0) long_hold--;
    else if (out_hold > 0) out_hold--;
    else if ((results_seen / 120) % 4 == 2) nr = 1'b1;
    else if ($urandom_range(0, 99) < 60) nr = 1'b1;
    else out_hold = gap_len();
    m_axis_tready <= nr;
  end

  // Watchdog: cycles with no word moving on either side
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic req_t alloc_req(logic [REQ_W-1:0] b);
    req_t r;
    r.is_free = 1'b0; r.bytes = b; r.addr = '0;
    return r;
  endfunction

  function automatic req_t free_req(logic [ADDR_W-1:0] a);
    req_t r;
    r.is_free = 1'b1; r.bytes = REQ_W'($urandom()); r.addr = a;
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned r, s;
    r = $urandom_range(0, 99);
    if (r < 50 || granted_q.size() == 0 && r < 85) begin
      s = $urandom_range(0, 99);
      if (s < 60) return alloc_req(REQ_W'($urandom_range(0, 64)));
      if (s < 85) return alloc_req(REQ_W'($urandom_range(65, 4096)));
      if (s < 97) return alloc_req(REQ_W'($urandom_range(4097, 1048576)));
      return alloc_req(REQ_W'($urandom_range(1048577, 2097151)));
    end
    if (r < 88 && granted_q.size() > 0)
      return free_req(ADDR_W'(granted_q[$urandom_range(0, granted_q.size() - 1)]));
    if (r < 93 && granted_q.size() > 0)
      return free_req(ADDR_W'(granted_q[$urandom_range(0, granted_q.size() - 1)] +
                              $urandom_range(1, 15)));
    if (r < 96 && granted_q.size() > 0)
      return free_req(ADDR_W'(granted_q[$urandom_range(0, granted_q.size() - 1)] + 16));
    return free_req(ADDR_W'($urandom_range(0, 1048575)));
  endfunction

  // Sample after the edge so that the driver and monitor updates are settled
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (req_q.size() > 0 || s_axis_tvalid || result_q.size() > 0 || m_axis_tvalid);
  endtask

  task automatic write_pool(logic [POOL_W-1:0] v);
    wait_drained();
    repeat (100) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lay_out_pool(v);
  endtask

  // Random words in small batches so frees track live grants
  task automatic run_random(int n);
    int left;
    left = n;
    while (left > 0) begin
      while (req_q.size() > 1) @(posedge clk_i);
      req_q.push_back(random_req());
      left--;
    end
  endtask

  initial begin
    lay_out_pool(POOL_RESET);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: sizes at the extremes, frees good and bad
    req_q.push_back(alloc_req(0));            // zero bytes gets one leaf
    req_q.push_back(alloc_req(1));
    req_q.push_back(alloc_req(16));
    req_q.push_back(alloc_req(17));
    req_q.push_back(alloc_req(1048576));      // whole tree, not free
    req_q.push_back(alloc_req(21'h1FFFFF));   // larger than the tree
    req_q.push_back(free_req(0));
    req_q.push_back(free_req(0));             // already free
    req_q.push_back(free_req(8));             // misaligned
    req_q.push_back(free_req(20'hFFFF0));     // free block at pool end
    req_q.push_back(free_req(32 + 16));       // a free leaf, not allocated
    req_q.push_back(free_req(32));
    req_q.push_back(free_req(16));
    req_q.push_back(free_req(64));
    req_q.push_back(alloc_req(1048576));      // whole pool once merged
    req_q.push_back(free_req(0));
    run_random(680);

    write_pool(21'd1000);                     // odd length, leaves in front taken
    req_q.push_back(alloc_req(1000));
    req_q.push_back(free_req(20'hFFFFF));     // beyond the pool
    run_random(400);

    write_pool(21'd8);                        // empty pool
    req_q.push_back(alloc_req(0));
    req_q.push_back(free_req(0));
    run_random(30);

    write_pool(21'd16);                       // a single leaf
    req_q.push_back(alloc_req(16));
    req_q.push_back(alloc_req(1));
    req_q.push_back(free_req(0));
    run_random(60);

    write_pool(21'h1FFFFF);                   // saturates to the full tree
    run_random(520);

    wait_drained();
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
